// ----- hw/rtl/gedd_pkg.sv -----
// ----------------------------------------------------------------------------
// gedd_pkg
// Shared types, widths and constants for the grayscale error-diffusion dither.
// ----------------------------------------------------------------------------
package gedd_pkg;

  localparam int GRAY_W     = 8;
  localparam int CFG_W      = 12;
  localparam int CARRY_W    = 10;
  localparam int LINE_W     = 11;
  localparam int ACC_W      = 13;
  localparam int ERR_W      = 10;
  localparam int SUM_W      = 10;
  localparam int PROD_W     = 20;
  localparam int DIV3_SHIFT = 11;

  localparam logic [CFG_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [SUM_W-1:0]  DIV3_RECIP = 10'd683;

  localparam logic signed [ACC_W-1:0] SAT_LO  = -13'sd256;
  localparam logic signed [ACC_W-1:0] SAT_HI  = 13'sd511;
  localparam logic signed [ERR_W-1:0] THRESH  = 10'sd128;
  localparam logic signed [ERR_W-1:0] WHITE   = 10'sd255;
  localparam logic signed [ACC_W-1:0] W_RIGHT = 13'sd7;
  localparam logic signed [ACC_W-1:0] W_DL    = 13'sd3;
  localparam logic signed [ACC_W-1:0] W_DOWN  = 13'sd5;
  localparam logic signed [ACC_W-1:0] DIV16_BIAS = 13'sd15;

  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic              first_row;
    logic              last;
    logic              first_col;
  } pix_t;

  // divide by 16, truncating toward zero
  function automatic logic signed [ACC_W-1:0] div16_trunc(input logic signed [ACC_W-1:0] p);
    logic signed [ACC_W-1:0] b;
    b = p[ACC_W-1] ? p + DIV16_BIAS : p;
    return b >>> 4;
  endfunction

endpackage

// ----- hw/rtl/grayscale_error_diffusion_dither.sv -----
// ----------------------------------------------------------------------------
// grayscale_error_diffusion_dither
// Takes one RGB pixel per clock in raster order and returns one dot per pixel,
// registered in stage 1 and then at the output, with row_end on the last
// pixel of each row. A pixel is averaged to gray, the errors from its left
// neighbor and from the row above are added, and the sum is thresholded;
// the error is spread 7/16, 3/16, 5/16, 1/16 to the right and the row below.
// The row below is kept in one line store of MAX_WIDTH x 11 bits with one
// write and one registered read port: it is read when the pixel is taken and
// written back when stage 1 fires, with the most recent write forwarded. The
// store needs no clearing; first_row must be set for the first row of a
// frame. Sustained rate is one pixel per clock; the input only stalls when
// the output register holds an untaken result.
// ----------------------------------------------------------------------------
module grayscale_error_diffusion_dither import gedd_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [GRAY_W-1:0] in_red,
  input  logic [GRAY_W-1:0] in_green,
  input  logic [GRAY_W-1:0] in_blue,
  input  logic              in_first_row,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_dot,
  output logic              out_row_end
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic              in_fire;
  logic              s1_valid;
  logic              s1_fire;
  pix_t              s1_pix;
  logic [CW-1:0]     s1_col;
  logic              rd_en;
  logic [CW-1:0]     rd_addr;
  logic [LINE_W-1:0] rd_data;
  logic              wr_en;
  logic [CW-1:0]     wr_addr;
  logic [LINE_W-1:0] wr_data;

  assign in_stall = s1_valid && !s1_fire;
  assign in_fire  = in_valid && !in_stall;

  gedd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .red         (in_red),
    .green       (in_green),
    .blue        (in_blue),
    .first_row   (in_first_row),
    .in_fire     (in_fire),
    .s1_fire     (s1_fire),
    .s1_valid    (s1_valid),
    .s1_pix      (s1_pix),
    .s1_col      (s1_col),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr)
  );

  gedd_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gedd_diffuse #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_diffuse (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (s1_valid),
    .s1_pix      (s1_pix),
    .s1_col      (s1_col),
    .rd_data     (rd_data),
    .out_stall   (out_stall),
    .s1_fire     (s1_fire),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .out_valid   (out_valid),
    .out_dot     (out_dot),
    .out_row_end (out_row_end)
  );

endmodule

// ----- hw/rtl/gedd_ram.sv -----
// ----------------------------------------------------------------------------
// gedd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gedd_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/gedd_front.sv -----
// ----------------------------------------------------------------------------
// gedd_front
// Width register, column tracking, gray conversion and line-store read issue.
// ----------------------------------------------------------------------------
module gedd_front import gedd_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [CFG_W-1:0]             cfg_wr_data,
  input  logic [GRAY_W-1:0]            red,
  input  logic [GRAY_W-1:0]            green,
  input  logic [GRAY_W-1:0]            blue,
  input  logic                         first_row,
  input  logic                         in_fire,
  input  logic                         s1_fire,
  output logic                         s1_valid,
  output pix_t                         s1_pix,
  output logic [$clog2(MAX_WIDTH)-1:0] s1_col,
  output logic                         rd_en,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_addr
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CMPW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

  logic [CFG_W-1:0]  width_r;
  logic [CW-1:0]     column_r, column_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  pix_t              s1_pix_r;
  logic [CW-1:0]     s1_col_r;

  logic [CMPW-1:0]   cfg_ext, max_ext, eff_w, col_ext, c_ext;
  logic [CW-1:0]     c;
  logic              last;
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;
  logic [GRAY_W-1:0] gray;

  always_comb begin
    cfg_ext = CMPW'(width_r);
    max_ext = CMPW'(MAX_WIDTH);
    if (width_r == '0) begin
      eff_w = CMPW'(1);
    end else if (cfg_ext > max_ext) begin
      eff_w = max_ext;
    end else begin
      eff_w = cfg_ext;
    end
    col_ext    = CMPW'(column_r);
    c_ext      = (col_ext >= eff_w) ? eff_w - CMPW'(1) : col_ext;
    last       = (c_ext + CMPW'(1)) >= eff_w;
    c          = c_ext[CW-1:0];
    column_nxt = in_fire ? (last ? '0 : c + CW'(1)) : column_r;
  end

  always_comb begin
    sum  = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
    prod = PROD_W'(sum) * PROD_W'(DIV3_RECIP);
    gray = prod[DIV3_SHIFT +: GRAY_W];
  end

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WIDTH_RST;
      column_r   <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        width_r <= cfg_wr_data;
      end
      column_r   <= column_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r <= '{gray: gray, first_row: first_row, last: last, first_col: (c == '0)};
      s1_col_r <= c;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_pix   = s1_pix_r;
  assign s1_col   = s1_col_r;
  assign rd_en    = in_fire;
  assign rd_addr  = c;

endmodule

// ----- hw/rtl/gedd_diffuse.sv -----
// ----------------------------------------------------------------------------
// gedd_diffuse
// Threshold and error spread; line-store write-back with forwarding; output
// register.
// ----------------------------------------------------------------------------
module gedd_diffuse import gedd_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         s1_valid,
  input  pix_t                         s1_pix,
  input  logic [$clog2(MAX_WIDTH)-1:0] s1_col,
  input  logic [LINE_W-1:0]            rd_data,
  input  logic                         out_stall,
  output logic                         s1_fire,
  output logic                         wr_en,
  output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  output logic [LINE_W-1:0]            wr_data,
  output logic                         out_valid,
  output logic                         out_dot,
  output logic                         out_row_end
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic signed [CARRY_W-1:0] carry_r, carry_nxt;
  logic signed [LINE_W-1:0]  pbl_r, pbl_nxt;
  logic signed [LINE_W-1:0]  pbh_r, pbh_nxt;
  logic                      def_valid_r, def_valid_nxt;
  logic [CW-1:0]             def_addr_r;
  logic [LINE_W-1:0]         def_data_r;
  logic                      fw_valid_r;
  logic [CW-1:0]             fw_addr_r;
  logic [LINE_W-1:0]         fw_data_r;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_dot_r;
  logic                      out_row_end_r;

  logic signed [LINE_W-1:0]  line_val, line_term;
  logic signed [ACC_W-1:0]   gray_ext, acc, acc_c;
  logic signed [ERR_W-1:0]   acc_sat, err;
  logic                      dot;
  logic signed [ACC_W-1:0]   err_x, e7, e3, e5, e1;
  logic signed [LINE_W-1:0]  pbl_new, below_left;
  logic                      own_we, def_go;
  logic [CW-1:0]             own_addr;
  logic [LINE_W-1:0]         own_data;

  assign s1_fire = s1_valid && (!out_valid_r || !out_stall);

  always_comb begin
    line_val  = (fw_valid_r && (fw_addr_r == s1_col)) ? $signed(fw_data_r) : $signed(rd_data);
    line_term = s1_pix.first_row ? '0 : line_val;
    gray_ext  = $signed({{(ACC_W-GRAY_W){1'b0}}, s1_pix.gray});
    acc       = gray_ext + ACC_W'(carry_r) + ACC_W'(line_term);
    if (acc < SAT_LO) begin
      acc_c = SAT_LO;
    end else if (acc > SAT_HI) begin
      acc_c = SAT_HI;
    end else begin
      acc_c = acc;
    end
    acc_sat    = ERR_W'(acc_c);
    dot        = acc_sat >= THRESH;
    err        = dot ? acc_sat - WHITE : acc_sat;
    err_x      = ACC_W'(err);
    e7         = div16_trunc(err_x * W_RIGHT);
    e3         = div16_trunc(err_x * W_DL);
    e5         = div16_trunc(err_x * W_DOWN);
    e1         = div16_trunc(err_x);
    pbl_new    = pbh_r + LINE_W'(e5);
    below_left = pbl_r + LINE_W'(e3);
  end

  always_comb begin
    carry_nxt = carry_r;
    pbl_nxt   = pbl_r;
    pbh_nxt   = pbh_r;
    if (s1_fire) begin
      if (s1_pix.last) begin
        carry_nxt = '0;
        pbl_nxt   = '0;
        pbh_nxt   = '0;
      end else begin
        carry_nxt = CARRY_W'(e7);
        pbl_nxt   = pbl_new;
        pbh_nxt   = LINE_W'(e1);
      end
    end
  end

  // row end past column 0 writes two entries; the second waits for a free slot
  always_comb begin
    own_we   = s1_fire && (!s1_pix.first_col || s1_pix.last);
    own_addr = s1_pix.first_col ? s1_col : s1_col - CW'(1);
    own_data = s1_pix.first_col ? pbl_new : below_left;
    def_go   = def_valid_r && !own_we && (!s1_valid || s1_fire);
    wr_en    = own_we || def_go;
    wr_addr  = own_we ? own_addr : def_addr_r;
    wr_data  = own_we ? own_data : def_data_r;
    if (s1_fire && s1_pix.last && !s1_pix.first_col) begin
      def_valid_nxt = 1'b1;
    end else if (def_go) begin
      def_valid_nxt = 1'b0;
    end else begin
      def_valid_nxt = def_valid_r;
    end
  end

  always_comb begin
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r     <= '0;
      pbl_r       <= '0;
      pbh_r       <= '0;
      def_valid_r <= 1'b0;
      fw_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      carry_r     <= carry_nxt;
      pbl_r       <= pbl_nxt;
      pbh_r       <= pbh_nxt;
      def_valid_r <= def_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        fw_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_pix.last && !s1_pix.first_col) begin
      def_addr_r <= s1_col;
      def_data_r <= pbl_new;
    end
    if (wr_en) begin
      fw_addr_r <= wr_addr;
      fw_data_r <= wr_data;
    end
    if (s1_fire) begin
      out_dot_r     <= dot;
      out_row_end_r <= s1_pix.last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_dot     = out_dot_r;
  assign out_row_end = out_row_end_r;

endmodule

// ----- hw/rtl/gedd_checker.sv -----
// ----------------------------------------------------------------------------
// gedd_checker
// Port-level checks for the dither block, bound to the top level.
// ----------------------------------------------------------------------------
module gedd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_dot,
  input logic out_row_end
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_dot) && $stable(out_row_end))
    else $error("result changed while stalled");

  // input only backs up behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // every transaction is followed by a valid result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##2 out_valid)
    else $error("result missing after transaction");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output valid after reset");

endmodule

bind grayscale_error_diffusion_dither gedd_checker u_gedd_checker (.*);
